// ===== hw/rtl/nqse_pkg.sv =====
// N-queens enumerator: shared widths, limits and the command/status structs
// passed between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nqse_pkg;

   localparam int MAX_N_DEF   = 16;
   localparam int SIZE_W      = 5;    // board_size register width
   localparam int ROW_W       = 4;    // row field per column in placement
   localparam int PLACE_W     = 64;
   localparam int COUNT_W     = 24;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = PLACE_W + COUNT_W;
   localparam int RSP_USER_W  = 1;
   localparam int SIZE_RESET  = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // controller -> datapath
   typedef struct packed {
      logic init;     // empty board, zero the solution count
      logic place;    // put a queen on the lowest free row of this column
      logic pop;      // take back the last queen
      logic load;     // capture the result into the output register
      logic found;    // with load: a new solution is being given
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic col_full;  // every column holds a queen
      logic col_zero;  // board is empty
      logic has_free;  // a legal row exists at or above the resume row
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/nqse_datapath.sv =====
// N-queens enumerator datapath: board stack, attack masks, free-row search,
// size register and result register. Uses nqse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nqse_datapath #(
   parameter int MAX_N = nqse_pkg::MAX_N_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [nqse_pkg::SIZE_W-1:0]    csr_wdata,
   input  wire nqse_pkg::cmd_type              cmd,
   output nqse_pkg::status_type                status,
   output logic                                rsp_found,
   output logic [nqse_pkg::PLACE_W-1:0]        rsp_placement,
   output logic [nqse_pkg::COUNT_W-1:0]        rsp_number
);
   import nqse_pkg::*;

   localparam int CW  = $clog2(MAX_N + 1);           // column count / row resume
   localparam int IW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int DW  = 2 * MAX_N - 1;               // diagonals
   localparam int DIW = (DW > 1) ? $clog2(DW) : 1;
   localparam int NRST = (SIZE_RESET > MAX_N) ? MAX_N : SIZE_RESET;

   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [CW-1:0]      row_from_ff, row_from_in;
   logic [MAX_N-1:0]   rows_ff, rows_in;
   logic [DW-1:0]      down_ff, down_in;
   logic [DW-1:0]      up_ff, up_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ROW_W-1:0]   col_rows_ff [MAX_N];

   logic [DW-1:0]      down_win, up_win;
   logic [MAX_N-1:0]   cand;
   logic [ROW_W-1:0]   pick;
   logic [CW-1:0]      col_dec;
   logic [ROW_W-1:0]   pop_row;
   logic [DIW-1:0]     place_dn_idx, pop_dn_idx, place_up_idx, pop_up_idx;
   logic [PLACE_W-1:0] packed_rows;
   logic [COUNT_W-1:0] count_next;

   // clamp the written size into 1..MAX_N
   always_comb begin
      n_in = n_ff;
      if (csr_wr_en) begin
         if (csr_wdata == '0) begin
            n_in = CW'(1);
         end else if (csr_wdata > SIZE_W'(MAX_N)) begin
            n_in = CW'(MAX_N);
         end else begin
            n_in = csr_wdata[CW-1:0];
         end
      end
   end

   // attack windows seen from the current column
   always_comb begin
      down_win = down_ff >> (DIW'(MAX_N - 1) - DIW'(col_ff));
      up_win   = up_ff >> DIW'(col_ff);
      for (int r = 0; r < MAX_N; r++) begin
         cand[r] = !rows_ff[r] && !down_win[r] && !up_win[r]
                   && (CW'(r) >= row_from_ff) && (CW'(r) < n_ff);
      end
      pick = '0;
      for (int r = MAX_N - 1; r >= 0; r--) begin
         if (cand[r]) begin
            pick = ROW_W'(r);
         end
      end
   end

   assign col_dec      = col_ff - CW'(1);
   assign pop_row      = col_rows_ff[col_dec[IW-1:0]];
   assign place_dn_idx = DIW'(pick) + DIW'(MAX_N - 1) - DIW'(col_ff);
   assign place_up_idx = DIW'(pick) + DIW'(col_ff);
   assign pop_dn_idx   = DIW'(pop_row) + DIW'(MAX_N - 1) - DIW'(col_dec);
   assign pop_up_idx   = DIW'(pop_row) + DIW'(col_dec);

   assign status.col_full = (col_ff >= n_ff);
   assign status.col_zero = (col_ff == '0);
   assign status.has_free = |cand;

   always_comb begin
      col_in      = col_ff;
      row_from_in = row_from_ff;
      rows_in     = rows_ff;
      down_in     = down_ff;
      up_in       = up_ff;
      if (cmd.init) begin
         col_in      = '0;
         row_from_in = '0;
         rows_in     = '0;
         down_in     = '0;
         up_in       = '0;
      end else if (cmd.place) begin
         col_in                = col_ff + CW'(1);
         row_from_in           = '0;
         rows_in[pick[IW-1:0]] = 1'b1;
         down_in[place_dn_idx] = 1'b1;
         up_in[place_up_idx]   = 1'b1;
      end else if (cmd.pop) begin
         col_in                   = col_dec;
         row_from_in              = CW'(pop_row) + CW'(1);
         rows_in[pop_row[IW-1:0]] = 1'b0;
         down_in[pop_dn_idx]      = 1'b0;
         up_in[pop_up_idx]        = 1'b0;
      end
   end

   always_comb begin
      packed_rows = '0;
      for (int c = 0; c < MAX_N; c++) begin
         if (CW'(c) < n_ff) begin
            packed_rows[ROW_W*c +: ROW_W] = col_rows_ff[c];
         end
      end
   end

   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

   always_comb begin
      count_in = count_ff;
      if (cmd.init) begin
         count_in = '0;
      end else if (cmd.load && cmd.found) begin
         count_in = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff        <= CW'(NRST);
         col_ff      <= '0;
         row_from_ff <= '0;
         rows_ff     <= '0;
         down_ff     <= '0;
         up_ff       <= '0;
         count_ff    <= '0;
      end else begin
         n_ff        <= n_in;
         col_ff      <= col_in;
         row_from_ff <= row_from_in;
         rows_ff     <= rows_in;
         down_ff     <= down_in;
         up_ff       <= up_in;
         count_ff    <= count_in;
      end
   end

   // stack of placed rows: written only when a queen goes down
   always_ff @(posedge clock) begin
      if (cmd.place) begin
         col_rows_ff[col_ff[IW-1:0]] <= pick;
      end
   end

   // result register (payload, no reset)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_found     <= cmd.found;
         rsp_placement <= cmd.found ? packed_rows : '0;
         rsp_number    <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/nqse_ctrl.sv =====
// N-queens enumerator controller: request/response handshake and the
// search sequencer (place, backtrack, finish). Uses nqse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nqse_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic                 req_restart,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic                 csr_wr_en,
   input  wire nqse_pkg::status_type status,
   output nqse_pkg::cmd_type         cmd
);
   import nqse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_BACK   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic started_ff, started_in;
   logic exhausted_ff, exhausted_in;
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      exhausted_in = exhausted_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_restart || !started_ff) begin
                  cmd.init     = 1'b1;
                  started_in   = 1'b1;
                  exhausted_in = 1'b0;
                  state_in     = ST_SEARCH;
               end else if (exhausted_ff) begin
                  found_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_BACK;
               end
            end
         end
         ST_BACK: begin
            if (status.col_zero) begin
               found_in     = 1'b0;
               exhausted_in = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.col_full) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (status.has_free) begin
               cmd.place = 1'b1;
            end else if (status.col_zero) begin
               found_in     = 1'b0;
               exhausted_in = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               cmd.found    = found_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a size change forces a fresh search on the next request
      if (csr_wr_en) begin
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         exhausted_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         exhausted_ff <= exhausted_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/n_queens_solution_enumerator_unit.sv =====
// N-queens solution enumerator, top level: wires controller to datapath.
// Depends on nqse_pkg, nqse_ctrl and nqse_datapath.
//
// Usage:
//  - Request channel (req_*): one transfer per wanted solution. req_tdata[0]
//    is restart: 1 starts over from the empty board, 0 asks for the next one.
//    The first request after reset or after a board_size write always starts
//    over.
//  - Response channel (rsp_*): one transfer per request. rsp_tuser[0] is the
//    found flag; rsp_tdata holds the placement (4 bits of row per column,
//    column 0 lowest) and the saturating solution count above it. When the
//    search has run out, found is 0, placement is 0 and the count holds.
//  - csr_wr_en/csr_wdata write board_size (0 acts as 1, above MAX_N as MAX_N).
//    Write only while no request is in flight.
// Sequencing: the search sequencer does one queen placement or one backtrack per
//  clock; after the request transfer it steps until a step sees the board full
//  or empty, then loads the result once the output register is free; a search
//  that had already run out goes straight to the result load. Steps per
//  solution depend on the board. One request is worked at a time; req_tready
//  is high only while the sequencer is idle, so a new request is not taken
//  until the last result is loaded.
// A finished result sits in the output register; the next request is taken
//  while it waits, but the following result is held until rsp_tready frees it.
// Reset (synchronous): board_size returns to 4 (MAX_N if smaller), no response
//  pending, search not started.
`timescale 1ns / 1ps
`default_nettype none

module n_queens_solution_enumerator_unit #(
   parameter int MAX_N = nqse_pkg::MAX_N_DEF   // largest board, 1..16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [nqse_pkg::REQ_DATA_W-1:0]    req_tdata,   // [0] restart
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [nqse_pkg::RSP_DATA_W-1:0]         rsp_tdata,   // [63:0] placement,
                                                                // [87:64] solution_number
   output logic [nqse_pkg::RSP_USER_W-1:0]         rsp_tuser,   // [0] found
   input  wire logic                               csr_wr_en,
   input  wire logic [nqse_pkg::SIZE_W-1:0]        csr_wdata    // board_size
);
   import nqse_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic                 found;
   logic [PLACE_W-1:0]   placement;
   logic [COUNT_W-1:0]   solution_number;

   nqse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .status      (status),
      .cmd         (cmd)
   );

   nqse_datapath #(
      .MAX_N (MAX_N)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_found     (found),
      .rsp_placement (placement),
      .rsp_number    (solution_number)
   );

   assign rsp_tdata = {solution_number, placement};
   assign rsp_tuser = found;

endmodule

`default_nettype wire

// ===== hw/rtl/nqse_checker.sv =====
// N-queens enumerator port checker plus its bind to the top level.
// Uses nqse_pkg widths; sees top-level ports only.
`timescale 1ns / 1ps
`default_nettype none

module nqse_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [nqse_pkg::REQ_DATA_W-1:0]    req_tdata,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [nqse_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic [nqse_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input wire logic                               csr_wr_en,
   input wire logic [nqse_pkg::SIZE_W-1:0]        csr_wdata
);
   import nqse_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no solution means empty placement
   a_empty_place: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[PLACE_W-1:0] == '0)
      else $error("placement nonzero without a solution");

   // a given solution is always counted
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[RSP_DATA_W-1:PLACE_W] != '0)
      else $error("solution given with zero count");

   // reset clears the response valid
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind n_queens_solution_enumerator_unit nqse_checker u_nqse_checker (.*);

`default_nettype wire
